// File: rtl/core/fsl_pkg.sv
// ---------------------------------------------------------------------------
// Follower steering law package
// Shared widths, mode codes, the bus between pipeline stages, the per-mode
// speed gains and the arctangent table for the CORDIC iterations.
// ---------------------------------------------------------------------------
`default_nettype none

package fsl_pkg;

    localparam int IN_W      = 16;   // Q4.12 coordinates
    localparam int FRAC_BITS = 12;
    localparam int GUARD     = 8;
    localparam int XY_W      = 28;   // coordinates with guard bits and CORDIC growth
    localparam int Z_W       = 34;   // Q30 angle accumulator
    localparam int MAX_STEPS = 24;
    localparam int TURN_W    = 17;
    localparam int SPEED_W   = 15;
    localparam int MODE_W    = 2;
    localparam int KQ_W      = 30;   // gain compensation, Q30
    localparam int GAIN_W    = 16;   // speed gain, Q16

    localparam logic [MODE_W-1:0] MODE_LINE     = 2'd0;
    localparam logic [MODE_W-1:0] MODE_TRIANGLE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_DIAMOND  = 2'd2;
    localparam logic [MODE_W-1:0] MODE_OTHER    = 2'd3;

    localparam logic signed [Z_W-1:0] HALF_PI_Q30 = 34'sd1686629713;
    localparam longint unsigned       KINF        = 64'd652032874;

    typedef struct packed {
        logic                   valid;
        logic                   zero;   // vector was (0,0): force outputs to 0
        logic [MODE_W-1:0]      mode;
        logic signed [XY_W-1:0] x;
        logic signed [XY_W-1:0] y;
        logic signed [Z_W-1:0]  z;
    } t_cordic_bus;

    // atan(2^-i) in Q30 radians
    function automatic logic signed [Z_W-1:0] atan_q30(input int i);
        logic signed [Z_W-1:0] v;
        case (i)
            0:  v = 34'sd843314857;
            1:  v = 34'sd497837829;
            2:  v = 34'sd263043837;
            3:  v = 34'sd133525159;
            4:  v = 34'sd67021687;
            5:  v = 34'sd33543516;
            6:  v = 34'sd16775851;
            7:  v = 34'sd8388437;
            8:  v = 34'sd4194283;
            9:  v = 34'sd2097149;
            10: v = 34'sd1048576;
            11: v = 34'sd524288;
            12: v = 34'sd262144;
            13: v = 34'sd131072;
            14: v = 34'sd65536;
            15: v = 34'sd32768;
            16: v = 34'sd16384;
            17: v = 34'sd8192;
            18: v = 34'sd4096;
            19: v = 34'sd2048;
            20: v = 34'sd1024;
            21: v = 34'sd512;
            22: v = 34'sd256;
            23: v = 34'sd128;
            default: v = '0;
        endcase
        return v;
    endfunction

    // speed gain per mode, Q16
    function automatic logic [GAIN_W-1:0] speed_gain(input logic [MODE_W-1:0] mode);
        logic [GAIN_W-1:0] g;
        case (mode)
            MODE_LINE:     g = 16'd32768;
            MODE_TRIANGLE: g = 16'd16384;
            MODE_DIAMOND:  g = 16'd16384;
            MODE_OTHER:    g = 16'd19661;
            default:       g = 16'd19661;
        endcase
        return g;
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/fsl_front.sv
// ---------------------------------------------------------------------------
// Follower steering law front end
// Adds the mode offset, flags the zero vector, scales in the guard bits and
// folds the left half plane by a quarter turn. One register stage.
// ---------------------------------------------------------------------------
`default_nettype none

module fsl_front (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_valid,
    input  wire logic [fsl_pkg::MODE_W-1:0]          i_mode,
    input  wire logic signed [fsl_pkg::IN_W-1:0]     i_leader_x,
    input  wire logic signed [fsl_pkg::IN_W-1:0]     i_leader_y,
    output fsl_pkg::t_cordic_bus                     o_bus
);

    localparam int OFS_W = fsl_pkg::IN_W + 1;
    localparam logic signed [OFS_W-1:0] Y_OFFSET =
        OFS_W'(1 << (fsl_pkg::FRAC_BITS - 1));

    logic signed [OFS_W-1:0]          y_ofs;
    logic signed [fsl_pkg::XY_W-1:0]  xg;
    logic signed [fsl_pkg::XY_W-1:0]  yg;
    fsl_pkg::t_cordic_bus             n_bus;
    fsl_pkg::t_cordic_bus             r_bus;

    always_comb begin
        y_ofs = OFS_W'(i_leader_y);
        if (i_mode == fsl_pkg::MODE_TRIANGLE || i_mode == fsl_pkg::MODE_DIAMOND) begin
            y_ofs = y_ofs + Y_OFFSET;
        end
        xg = fsl_pkg::XY_W'(i_leader_x) <<< fsl_pkg::GUARD;
        yg = fsl_pkg::XY_W'(y_ofs) <<< fsl_pkg::GUARD;

        n_bus.valid = i_valid;
        n_bus.mode  = i_mode;
        n_bus.zero  = (i_leader_x == '0) && (y_ofs == '0);
        if (xg < 0) begin
            // rotate into the right half plane
            if (yg >= 0) begin
                n_bus.x = yg;
                n_bus.y = -xg;
                n_bus.z = fsl_pkg::HALF_PI_Q30;
            end else begin
                n_bus.x = -yg;
                n_bus.y = xg;
                n_bus.z = -fsl_pkg::HALF_PI_Q30;
            end
        end else begin
            n_bus.x = xg;
            n_bus.y = yg;
            n_bus.z = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bus.valid <= 1'b0;
        end else begin
            r_bus <= n_bus;
        end
    end

    assign o_bus = r_bus;

endmodule

`default_nettype wire

// File: rtl/core/fsl_cordic_stage.sv
// ---------------------------------------------------------------------------
// Follower steering law CORDIC stage
// One vectoring micro-rotation by atan(2^-STAGE), registered.
// ---------------------------------------------------------------------------
`default_nettype none

module fsl_cordic_stage #(
    parameter int STAGE = 0
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  fsl_pkg::t_cordic_bus  i_bus,
    output fsl_pkg::t_cordic_bus  o_bus
);

    localparam logic signed [fsl_pkg::Z_W-1:0] ATAN = fsl_pkg::atan_q30(STAGE);

    logic signed [fsl_pkg::XY_W-1:0] xs;
    logic signed [fsl_pkg::XY_W-1:0] ys;
    fsl_pkg::t_cordic_bus            n_bus;
    fsl_pkg::t_cordic_bus            r_bus;

    always_comb begin
        xs    = i_bus.x >>> STAGE;
        ys    = i_bus.y >>> STAGE;
        n_bus = i_bus;
        // drive y toward zero
        if (i_bus.y < 0) begin
            n_bus.x = i_bus.x - ys;
            n_bus.y = i_bus.y + xs;
            n_bus.z = i_bus.z - ATAN;
        end else begin
            n_bus.x = i_bus.x + ys;
            n_bus.y = i_bus.y - xs;
            n_bus.z = i_bus.z + ATAN;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bus.valid <= 1'b0;
        end else begin
            r_bus <= n_bus;
        end
    end

    assign o_bus = r_bus;

endmodule

`default_nettype wire

// File: rtl/core/fsl_scale.sv
// ---------------------------------------------------------------------------
// Follower steering law output scaling
// Gain-compensates the magnitude, applies the mode speed gain and rounds the
// bearing into the turn rate. Four register stages, the last one drives
// the result ports.
// ---------------------------------------------------------------------------
`default_nettype none

module fsl_scale #(
    parameter int CORDIC_STEPS = 16
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  fsl_pkg::t_cordic_bus                   i_bus,
    output logic                                   o_done,
    output logic signed [fsl_pkg::TURN_W-1:0]      o_turn_rate,
    output logic [fsl_pkg::SPEED_W-1:0]            o_forward_speed
);

    localparam longint unsigned K_FULL = fsl_pkg::KINF +
        (2 * fsl_pkg::KINF) / (64'd3 << (2 * CORDIC_STEPS));
    localparam logic [fsl_pkg::KQ_W-1:0] K_Q30 = fsl_pkg::KQ_W'(K_FULL);

    localparam int XU_W   = fsl_pkg::XY_W - 1;
    localparam int P1_W   = XU_W + fsl_pkg::KQ_W;
    localparam int DIST_W = P1_W - 30 + 1;
    localparam int P2_W   = DIST_W + fsl_pkg::GAIN_W;
    localparam int SP_SH  = 16 + fsl_pkg::GUARD;
    localparam int SP_W   = P2_W - SP_SH + 1;
    localparam int TSH    = 28 - fsl_pkg::FRAC_BITS;
    localparam int Z_W    = fsl_pkg::Z_W;

    localparam logic signed [Z_W-1:0] TURN_MAX = Z_W'((1 << (fsl_pkg::TURN_W - 1)) - 1);
    localparam logic signed [Z_W-1:0] TURN_MIN = -Z_W'(1 << (fsl_pkg::TURN_W - 1));
    localparam logic [SP_W-1:0] SPEED_MAX = SP_W'((1 << fsl_pkg::SPEED_W) - 1);

    // stage 1: magnitude times K, turn rate rounded
    logic [XU_W-1:0]                   xu;
    logic signed [Z_W-1:0]             z_rnd;
    logic signed [Z_W-1:0]             t_full;
    logic signed [fsl_pkg::TURN_W-1:0] n_turn1;
    logic                              r_v1;
    logic                              r_zero1;
    logic [fsl_pkg::MODE_W-1:0]        r_mode1;
    logic [P1_W-1:0]                   r_p1;
    logic signed [fsl_pkg::TURN_W-1:0] r_turn1;

    always_comb begin
        xu = (i_bus.x < 0) ? '0 : XU_W'(i_bus.x);
        z_rnd  = i_bus.z + Z_W'(1 << (TSH - 1));
        t_full = z_rnd >>> TSH;
        if (t_full > TURN_MAX) begin
            n_turn1 = TURN_MAX[fsl_pkg::TURN_W-1:0];
        end else if (t_full < TURN_MIN) begin
            n_turn1 = TURN_MIN[fsl_pkg::TURN_W-1:0];
        end else begin
            n_turn1 = t_full[fsl_pkg::TURN_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else begin
            r_v1 <= i_bus.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_zero1 <= i_bus.zero;
        r_mode1 <= i_bus.mode;
        r_p1    <= P1_W'(xu) * P1_W'(K_Q30);
        r_turn1 <= n_turn1;
    end

    // stage 2: round to distance, look up mode gain
    logic [P1_W:0]                     p1_rnd;
    logic                              r_v2;
    logic                              r_zero2;
    logic [DIST_W-1:0]                 r_dist2;
    logic [fsl_pkg::GAIN_W-1:0]        r_gain2;
    logic signed [fsl_pkg::TURN_W-1:0] r_turn2;

    assign p1_rnd = {1'b0, r_p1} + (P1_W+1)'(64'd1 << 29);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else begin
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_zero2 <= r_zero1;
        r_dist2 <= p1_rnd[P1_W:30];
        r_gain2 <= fsl_pkg::speed_gain(r_mode1);
        r_turn2 <= r_turn1;
    end

    // stage 3: distance times speed gain
    logic                              r_v3;
    logic                              r_zero3;
    logic [P2_W-1:0]                   r_p2;
    logic signed [fsl_pkg::TURN_W-1:0] r_turn3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else begin
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        r_zero3 <= r_zero2;
        r_p2    <= P2_W'(r_dist2) * P2_W'(r_gain2);
        r_turn3 <= r_turn2;
    end

    // stage 4: round, saturate, zero-vector override
    logic [P2_W:0]                     p2_rnd;
    logic [SP_W-1:0]                   sp_full;
    logic [fsl_pkg::SPEED_W-1:0]       n_speed;
    logic signed [fsl_pkg::TURN_W-1:0] n_turn;
    logic                              r_done;
    logic signed [fsl_pkg::TURN_W-1:0] r_turn;
    logic [fsl_pkg::SPEED_W-1:0]       r_speed;

    always_comb begin
        p2_rnd  = {1'b0, r_p2} + (P2_W+1)'(64'd1 << (SP_SH - 1));
        sp_full = p2_rnd[P2_W:SP_SH];
        n_speed = (sp_full > SPEED_MAX) ? SPEED_MAX[fsl_pkg::SPEED_W-1:0]
                                        : sp_full[fsl_pkg::SPEED_W-1:0];
        n_turn  = r_turn3;
        if (r_zero3) begin
            n_speed = '0;
            n_turn  = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        r_turn  <= n_turn;
        r_speed <= n_speed;
    end

    assign o_done          = r_done;
    assign o_turn_rate     = r_turn;
    assign o_forward_speed = r_speed;

endmodule

`default_nettype wire

// File: rtl/core/follower_steering_law.sv
// ---------------------------------------------------------------------------
// Follower steering law
// Leader-relative position in, turn-rate and forward-speed command out, via
// a fully unrolled CORDIC vectoring pipeline.
// ---------------------------------------------------------------------------
// A pose is taken on any cycle that start is high; busy never rises, so one
// pose per clock is sustained. The result appears on o_turn_rate and
// o_forward_speed, qualified by a one-cycle o_done strobe, behind one
// register for the offset and half-plane fold, one per CORDIC
// micro-rotation, and four for the magnitude and gain multiplies and the
// final rounding. Results cannot be held off, so capture them on o_done.
// The steering mode register is written through the cfg channel (always
// ready) and should only change while no pose is in flight.
// ---------------------------------------------------------------------------
`default_nettype none

module follower_steering_law #(
    parameter int CORDIC_STEPS = 16
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                start,
    output logic                                     busy,
    input  wire logic signed [fsl_pkg::IN_W-1:0]     i_leader_x,
    input  wire logic signed [fsl_pkg::IN_W-1:0]     i_leader_y,
    output logic                                     o_done,
    output logic signed [fsl_pkg::TURN_W-1:0]        o_turn_rate,
    output logic [fsl_pkg::SPEED_W-1:0]              o_forward_speed,
    input  wire logic                                i_cfg_valid,
    output logic                                     o_cfg_ready,
    input  wire logic [fsl_pkg::MODE_W-1:0]          i_cfg_data
);

    logic [fsl_pkg::MODE_W-1:0] r_mode;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= fsl_pkg::MODE_LINE;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_mode <= i_cfg_data;
        end
    end

    assign o_cfg_ready = 1'b1;
    assign busy        = 1'b0;

    fsl_pkg::t_cordic_bus chain [CORDIC_STEPS+1];

    fsl_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (start && !busy),
        .i_mode     (r_mode),
        .i_leader_x (i_leader_x),
        .i_leader_y (i_leader_y),
        .o_bus      (chain[0])
    );

    for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_stage
        fsl_cordic_stage #(
            .STAGE (g)
        ) u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_bus   (chain[g]),
            .o_bus   (chain[g+1])
        );
    end

    fsl_scale #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_scale (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_bus           (chain[CORDIC_STEPS]),
        .o_done          (o_done),
        .o_turn_rate     (o_turn_rate),
        .o_forward_speed (o_forward_speed)
    );

endmodule

`default_nettype wire
